FILE: rtl/vertex_normal_accumulator_top_macros.svh
// Assertion macros used by vertex_normal_accumulator_top.
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define VNA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vna check failed");
`define VNA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vna check failed");
`else
`define VNA_ASSERT(label, ante, cons)
`define VNA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/vna_pkg.sv
`timescale 1ns / 1ps
package vna_pkg;

    localparam int IDX_W   = 10;
    localparam int FIELD_W = 16;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 62;
    localparam int LEN_W   = 31;
    localparam int Q_W     = 15;
    localparam int REM_W   = 46;
    localparam int FRAC_W  = 14;

    typedef enum logic [1:0] {
        OP_POS  = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PWRITE,
        S_TRD_A,
        S_TRD_B,
        S_TRD_C,
        S_TWAIT,
        S_TMUL,
        S_ARD,
        S_AWR,
        S_NRD,
        S_NLOAD,
        S_NSHIFT,
        S_NSQ,
        S_NSINIT,
        S_NSQRT,
        S_NDINIT,
        S_NDIV,
        S_RESULT
    } state_t;

endpackage

FILE: rtl/vna_if.sv
`timescale 1ns / 1ps
interface vna_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [9:0]                vertex_index;
    logic signed [15:0]        pos_x;
    logic signed [15:0]        pos_y;
    logic signed [15:0]        pos_z;
    logic [9:0]                corner_a;
    logic [9:0]                corner_b;
    logic [9:0]                corner_c;

    modport source (
        output valid, operation, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, operation, vertex_index, pos_x, pos_y, pos_z,
               corner_a, corner_b, corner_c,
        output ready
    );
endinterface

interface vna_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

FILE: rtl/vertex_normal_accumulator_top.sv
`timescale 1ns / 1ps
// Triangle: 3 position reads, 6 products on the shared multiplier and 3 accumulator
// read-modify-writes on the accumulator RAM. Normal read: the one-bit-a-cycle scaling
// shift, the 31-step square root and three 15-step divides, then the result waits out
// any response stall; a zero sum goes straight to the result.
// One request at a time. Reset (async, active low) clears control, then a
// clearing pass over all VERTEX_DEPTH entries zeroes the accumulators before ready rises.
`include "vertex_normal_accumulator_top_macros.svh"
module vertex_normal_accumulator_top
    import vna_pkg::*;
#(
    parameter int VERTEX_DEPTH = 1024,
    parameter int COORD_WIDTH  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    vna_cmd_if.sink   cmd,
    vna_rsp_if.source rsp
);

    localparam int AW    = $clog2(VERTEX_DEPTH);
    localparam int CW    = COORD_WIDTH;
    localparam int PW    = 3 * CW;
    localparam int MUL_W = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;

    state_t state_reg, state_next;

    logic [AW-1:0]        clr_cnt_reg;
    logic [2:0]           mul_cnt_reg;
    logic [1:0]           sel_reg;
    logic [3:0]           k_reg;
    logic                 out_valid_reg;

    logic [IDX_W-1:0]     vi_reg, ca_reg, cb_reg, cc_reg;
    logic [PW-1:0]        pw_reg;
    logic [PW-1:0]        pa_reg, pb_reg;
    logic signed [CW:0]   e1_reg [3];
    logic signed [CW:0]   e2_reg [3];
    logic [ACC_W-1:0]     cross_reg [3];
    logic [ACC_W-1:0]     m_reg [3];
    logic                 sign_reg [3];
    logic [SUM_W-1:0]     sum_reg, s_reg, r_reg, bit_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [REM_W-1:0]     rem_reg, dvs_reg;
    logic [Q_W-1:0]       q_reg;
    logic [FIELD_W-1:0]   res_reg [3];
    logic                 res_deg_reg;
    logic [FIELD_W-1:0]   on_x_reg, on_y_reg, on_z_reg;
    logic                 on_deg_reg;

    logic                 pos_we, acc_we;
    logic [AW-1:0]        pos_raddr, acc_waddr, acc_raddr;
    logic [3*ACC_W-1:0]   acc_wdata, acc_rdata;
    logic [PW-1:0]        pos_rdata;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;

    logic                 accept, out_free;
    logic                 vi_ok, tri_ok;
    logic [ACC_W-1:0]     max_mag;
    logic [AW-1:0]        corner_addr;
    logic [ACC_W-1:0]     acc_lane [3];
    logic [ACC_W-1:0]     mag_now [3];
    logic                 acc_zero;
    logic [SUM_W:0]       trial;
    logic                 rem_ge;
    logic [Q_W-1:0]       q_next;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign vi_ok    = 32'(cmd.vertex_index) < VERTEX_DEPTH;
    assign tri_ok   = (32'(cmd.corner_a) < VERTEX_DEPTH) && (32'(cmd.corner_b) < VERTEX_DEPTH)
                   && (32'(cmd.corner_c) < VERTEX_DEPTH);

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.normal_x   = on_x_reg;
    assign rsp.normal_y   = on_y_reg;
    assign rsp.normal_z   = on_z_reg;
    assign rsp.degenerate = on_deg_reg;

    always_comb
    begin
        max_mag = m_reg[0];
        if (m_reg[1] > max_mag)
        begin
            max_mag = m_reg[1];
        end
        if (m_reg[2] > max_mag)
        begin
            max_mag = m_reg[2];
        end
    end

    always_comb
    begin
        case (sel_reg)
            2'd0:    corner_addr = AW'(ca_reg);
            2'd1:    corner_addr = AW'(cb_reg);
            default: corner_addr = AW'(cc_reg);
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_lane[i] = acc_rdata[i*ACC_W +: ACC_W];
            mag_now[i]  = acc_lane[i][ACC_W-1] ? (~acc_lane[i] + 1'b1) : acc_lane[i];
        end
        acc_zero = (acc_rdata == '0);
    end

    assign trial  = {1'b0, r_reg} + {1'b0, bit_reg};
    assign rem_ge = rem_reg >= dvs_reg;
    assign q_next = {q_reg[Q_W-2:0], rem_ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_cnt_reg) == VERTEX_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_POS:  state_next = vi_ok ? S_PWRITE : S_IDLE;
                        OP_TRI:  state_next = tri_ok ? S_TRD_A : S_IDLE;
                        OP_READ: state_next = vi_ok ? S_NRD : S_RESULT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PWRITE: state_next = S_IDLE;
            S_TRD_A:  state_next = S_TRD_B;
            S_TRD_B:  state_next = S_TRD_C;
            S_TRD_C:  state_next = S_TWAIT;
            S_TWAIT:  state_next = S_TMUL;
            S_TMUL:   state_next = (mul_cnt_reg == 3'd6) ? S_ARD : S_TMUL;
            S_ARD:    state_next = S_AWR;
            S_AWR:    state_next = (sel_reg == 2'd2) ? S_IDLE : S_ARD;
            S_NRD:    state_next = S_NLOAD;
            S_NLOAD:  state_next = acc_zero ? S_RESULT : S_NSHIFT;
            S_NSHIFT:
            begin
                if ((max_mag[ACC_W-1:29] == '0) || (max_mag[ACC_W-1:30] != '0))
                begin
                    state_next = S_NSHIFT;
                end
                else
                begin
                    state_next = S_NSQ;
                end
            end
            S_NSQ:    state_next = (mul_cnt_reg == 3'd3) ? S_NSINIT : S_NSQ;
            S_NSINIT: state_next = S_NSQRT;
            S_NSQRT:  state_next = bit_reg[0] ? S_NDINIT : S_NSQRT;
            S_NDINIT: state_next = S_NDIV;
            S_NDIV:
            begin
                if (k_reg == 4'(Q_W - 1))
                begin
                    state_next = (sel_reg == 2'd2) ? S_RESULT : S_NDINIT;
                end
            end
            S_RESULT: state_next = out_free ? S_IDLE : S_RESULT;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory and multiplier controls
    always_comb
    begin
        pos_we    = 1'b0;
        acc_we    = 1'b0;
        pos_raddr = AW'(ca_reg);
        acc_raddr = AW'(vi_reg);
        acc_waddr = AW'(vi_reg);
        acc_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = clr_cnt_reg;
            end
            S_PWRITE:
            begin
                pos_we = 1'b1;
                acc_we = 1'b1;
            end
            S_TRD_A: pos_raddr = AW'(ca_reg);
            S_TRD_B: pos_raddr = AW'(cb_reg);
            S_TRD_C: pos_raddr = AW'(cc_reg);
            S_TMUL:
            begin
                case (mul_cnt_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(e1_reg[1]);
                        mul_b = MUL_W'(e2_reg[2]);
                    end
                    3'd1:
                    begin
                        mul_a = MUL_W'(e1_reg[2]);
                        mul_b = MUL_W'(e2_reg[1]);
                    end
                    3'd2:
                    begin
                        mul_a = MUL_W'(e1_reg[2]);
                        mul_b = MUL_W'(e2_reg[0]);
                    end
                    3'd3:
                    begin
                        mul_a = MUL_W'(e1_reg[0]);
                        mul_b = MUL_W'(e2_reg[2]);
                    end
                    3'd4:
                    begin
                        mul_a = MUL_W'(e1_reg[0]);
                        mul_b = MUL_W'(e2_reg[1]);
                    end
                    default:
                    begin
                        mul_a = MUL_W'(e1_reg[1]);
                        mul_b = MUL_W'(e2_reg[0]);
                    end
                endcase
            end
            S_ARD: acc_raddr = corner_addr;
            S_AWR:
            begin
                acc_we    = 1'b1;
                acc_waddr = corner_addr;
                for (int i = 0; i < 3; i++)
                begin
                    acc_wdata[i*ACC_W +: ACC_W] = acc_lane[i] + cross_reg[i];
                end
            end
            S_NSQ:
            begin
                case (mul_cnt_reg)
                    3'd0:    mul_a = MUL_W'($signed({1'b0, m_reg[0][29:0]}));
                    3'd1:    mul_a = MUL_W'($signed({1'b0, m_reg[1][29:0]}));
                    default: mul_a = MUL_W'($signed({1'b0, m_reg[2][29:0]}));
                endcase
                mul_b = mul_a;
            end
            default:
            begin
                pos_we = 1'b0;
            end
        endcase
    end

    vna_ram #(.WIDTH(PW), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (AW'(vi_reg)),
        .wdata (pw_reg),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(3 * ACC_W), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    vna_mul #(.W(MUL_W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            mul_cnt_reg   <= '0;
            sel_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((state_reg == S_TMUL) || (state_reg == S_NSQ))
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end
            else
            begin
                mul_cnt_reg <= '0;
            end
            if ((state_reg == S_IDLE) || (state_reg == S_NSINIT))
            begin
                sel_reg <= '0;
            end
            else if ((state_reg == S_AWR)
                     || ((state_reg == S_NDIV) && (k_reg == 4'(Q_W - 1))))
            begin
                sel_reg <= sel_reg + 1'b1;
            end
            if (state_reg == S_NDIV)
            begin
                k_reg <= k_reg + 1'b1;
            end
            else
            begin
                k_reg <= '0;
            end
            if ((state_reg == S_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                vi_reg      <= cmd.vertex_index;
                ca_reg      <= cmd.corner_a;
                cb_reg      <= cmd.corner_b;
                cc_reg      <= cmd.corner_c;
                pw_reg      <= {CW'($unsigned(cmd.pos_z)), CW'($unsigned(cmd.pos_y)),
                                CW'($unsigned(cmd.pos_x))};
                res_reg[0]  <= '0;
                res_reg[1]  <= '0;
                res_reg[2]  <= '0;
                res_deg_reg <= 1'b1;
            end
            S_TRD_B: pa_reg <= pos_rdata;
            S_TRD_C: pb_reg <= pos_rdata;
            S_TWAIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= $signed({pb_reg[i*CW+CW-1], pb_reg[i*CW +: CW]})
                               - $signed({pa_reg[i*CW+CW-1], pa_reg[i*CW +: CW]});
                    e2_reg[i] <= $signed({pos_rdata[i*CW+CW-1], pos_rdata[i*CW +: CW]})
                               - $signed({pa_reg[i*CW+CW-1], pa_reg[i*CW +: CW]});
                    cross_reg[i] <= '0;
                end
            end
            S_TMUL:
            begin
                if (mul_cnt_reg != 3'd0)
                begin
                    if (mul_cnt_reg[0])
                    begin
                        cross_reg[2'((mul_cnt_reg - 3'd1) >> 1)] <=
                            cross_reg[2'((mul_cnt_reg - 3'd1) >> 1)] + ACC_W'(prod);
                    end
                    else
                    begin
                        cross_reg[2'((mul_cnt_reg - 3'd1) >> 1)] <=
                            cross_reg[2'((mul_cnt_reg - 3'd1) >> 1)] - ACC_W'(prod);
                    end
                end
            end
            S_NLOAD:
            begin
                res_deg_reg <= acc_zero;
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i]    <= mag_now[i];
                    sign_reg[i] <= acc_lane[i][ACC_W-1];
                end
            end
            S_NSHIFT:
            begin
                sum_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (max_mag[ACC_W-1:29] == '0)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                    else if (max_mag[ACC_W-1:30] != '0)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
            end
            S_NSQ:
            begin
                if (mul_cnt_reg != 3'd0)
                begin
                    sum_reg <= sum_reg + SUM_W'(prod);
                end
            end
            S_NSINIT:
            begin
                s_reg   <= sum_reg;
                r_reg   <= '0;
                bit_reg <= SUM_W'(1) << (SUM_W - 2);
            end
            S_NSQRT:
            begin
                if ({1'b0, s_reg} >= trial)
                begin
                    s_reg <= SUM_W'({1'b0, s_reg} - trial);
                    r_reg <= (r_reg >> 1) + bit_reg;
                    if (bit_reg[0])
                    begin
                        len_reg <= LEN_W'((r_reg >> 1) + bit_reg);
                    end
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                    if (bit_reg[0])
                    begin
                        len_reg <= LEN_W'(r_reg >> 1);
                    end
                end
                bit_reg <= bit_reg >> 2;
            end
            S_NDINIT:
            begin
                rem_reg <= {2'b00, m_reg[sel_reg][29:0], FRAC_W'(0)}
                         + REM_W'(len_reg >> 1);
                dvs_reg <= REM_W'(len_reg) << FRAC_W;
                q_reg   <= '0;
            end
            S_NDIV:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= q_next;
                if (k_reg == 4'(Q_W - 1))
                begin
                    res_reg[sel_reg] <= sign_reg[sel_reg] ? (~{1'b0, q_next} + 1'b1)
                                                          : {1'b0, q_next};
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    on_x_reg   <= res_reg[0];
                    on_y_reg   <= res_reg[1];
                    on_z_reg   <= res_reg[2];
                    on_deg_reg <= res_deg_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `VNA_ASSERT(a_no_result_in_clear, state_reg == S_CLEAR, !rsp.valid)
    `VNA_ASSERT_NEXT(a_busy_after_accept, accept && (state_next != S_IDLE), !cmd.ready)
    `VNA_ASSERT(a_degenerate_zero, rsp.valid && rsp.degenerate,
                (rsp.normal_x == '0) && (rsp.normal_y == '0) && (rsp.normal_z == '0))
    `VNA_ASSERT(a_scaled_range, state_reg == S_NSQ,
                max_mag[ACC_W-1:29] == (ACC_W-29)'(1))
    `VNA_ASSERT(a_unit_bound, rsp.valid && !rsp.degenerate,
                (rsp.normal_x <= 16'sd16384) && (rsp.normal_x >= -16'sd16384))

endmodule

FILE: rtl/vna_ram.sv
`timescale 1ns / 1ps
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/vna_mul.sv
`timescale 1ns / 1ps
module vna_mul #(
    parameter int W = 31
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule
